// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file apal_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define CHK_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("check failed: name");

// Property checked at every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("check failed: name");

`endif

// ===== rtl/apal_pkg.sv =====
package apal_pkg;

   localparam int LINE_COUNT   = 10;
   localparam int OUTPUT_COUNT = 7;

   localparam int CODE_W      = 4;
   localparam int CODES_W     = CODE_W * OUTPUT_COUNT;
   localparam int LINE_IDX_W  = 4;
   localparam int OUT_IDX_W   = 3;
   localparam int WEB_W       = 2;
   localparam int MODE_W      = 2;
   localparam int STATE_IDX_W = 2;

   localparam int CSR_DATA_W  = (CODES_W > LINE_COUNT) ? CODES_W : LINE_COUNT;
   localparam int CSR_INDEX_W = 2;

   localparam int REQ_FIELDS_W = LINE_COUNT + WEB_W + OUT_IDX_W + MODE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 + OUTPUT_COUNT;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Reset condition codes: output 0 in the lowest nibble.
   localparam logic [63:0] CODES_RESET_WIDE = 64'h0000_0000_0BBB_B421;
   localparam logic [CODES_W-1:0] CODES_RESET = CODES_RESET_WIDE[CODES_W-1:0];
   localparam logic [LINE_IDX_W-1:0] ARM_IDX_RESET    = LINE_IDX_W'(0);
   localparam logic [LINE_IDX_W-1:0] DISARM_IDX_RESET = LINE_IDX_W'(1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_NORMAL = 2'd0,
      CSR_COND_CODES  = 2'd1,
      CSR_ARM_IDX     = 2'd2,
      CSR_DISARM_IDX  = 2'd3
   } csr_index_type;

   typedef enum logic [WEB_W-1:0] {
      WEB_NONE   = 2'd0,
      WEB_ARM    = 2'd1,
      WEB_DISARM = 2'd2,
      WEB_UNUSED = 2'd3
   } web_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_AUTO   = 2'd0,
      MODE_ON     = 2'd1,
      MODE_OFF    = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   localparam logic KIND_TICK     = 1'b0;
   localparam logic KIND_OVERRIDE = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [LINE_COUNT-1:0] line_levels;
      logic [WEB_W-1:0]      web_command;
      logic [OUT_IDX_W-1:0]  override_index;
      logic [MODE_W-1:0]     override_mode;
   } item_type;

   typedef struct packed {
      logic [LINE_COUNT-1:0] line_normal;
      logic [CODES_W-1:0]    cond_codes;
      logic [LINE_IDX_W-1:0] arm_idx;
      logic [LINE_IDX_W-1:0] disarm_idx;
   } cfg_type;

   // Set of panel states selected by a condition code.
   // Bit {violated, armed}: 0 disarmed/clear, 1 armed/clear,
   // 2 disarmed/violated, 3 armed/violated.
   function automatic logic [3:0] cond_set(input logic [CODE_W-1:0] code);
      logic [3:0] set;
      case (code)
         4'd1:    set = 4'h1;
         4'd2:    set = 4'h2;
         4'd3:    set = 4'h4;
         4'd4:    set = 4'h8;
         4'd5:    set = 4'h6;
         4'd6:    set = 4'h7;
         4'd7:    set = 4'hC;
         4'd8:    set = 4'hD;
         4'd9:    set = 4'hE;
         4'd10:   set = 4'hF;
         default: set = 4'h0;
      endcase
      return set;
   endfunction

endpackage

// ===== rtl/alarm_panel_arm_latch_outputs_top.sv =====
// Alarm panel arm/violation latch and output drive. Each item accepted on req_ (tuser 0: a
// polling tick with line levels and a web command, tuser 1: an output override) yields one
// result on rsp_ with armed, violated and the drive bits after that item. An item passes an
// input register and one combinational step into the result register. One item is taken every
// cycle while rsp_tready stays high; the result register and the input register let a new item
// be taken while a result waits. Write the csr_ port only while no item is in flight.
module alarm_panel_arm_latch_outputs_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // line_levels[9:0], web_command[11:10], override_index[14:12], override_mode[16:15]
   input  logic [apal_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // is_armed[0], is_violated[1], output_drive[8:2]
   output logic [apal_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [apal_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [apal_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   apal_pkg::cfg_type  cfg;
   apal_pkg::item_type item;
   logic               item_valid;
   logic               core_ready;

   apal_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   apal_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .core_ready (core_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   apal_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .core_ready (core_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/apal_csr.sv =====
module apal_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [apal_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [apal_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output apal_pkg::cfg_type                 cfg
);

   apal_pkg::cfg_type cfg_ff;
   apal_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (apal_pkg::csr_index_type'(csr_index))
            apal_pkg::CSR_LINE_NORMAL:
               cfg_in.line_normal = csr_wdata[apal_pkg::LINE_COUNT-1:0];
            apal_pkg::CSR_COND_CODES:
               cfg_in.cond_codes = csr_wdata[apal_pkg::CODES_W-1:0];
            apal_pkg::CSR_ARM_IDX:
               cfg_in.arm_idx = csr_wdata[apal_pkg::LINE_IDX_W-1:0];
            apal_pkg::CSR_DISARM_IDX:
               cfg_in.disarm_idx = csr_wdata[apal_pkg::LINE_IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_normal <= '0;
         cfg_ff.cond_codes  <= apal_pkg::CODES_RESET;
         cfg_ff.arm_idx     <= apal_pkg::ARM_IDX_RESET;
         cfg_ff.disarm_idx  <= apal_pkg::DISARM_IDX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/apal_in_reg.sv =====
module apal_in_reg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [apal_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic                             core_ready,
   output logic                             item_valid,
   output apal_pkg::item_type               item
);

   logic               valid_ff;
   logic               valid_in;
   apal_pkg::item_type item_ff;
   apal_pkg::item_type item_in;
   logic               take;

   // Accept when the stage is empty or drains into the core this cycle.
   assign req_tready = !valid_ff || core_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      item_in.kind           = req_tuser;
      item_in.line_levels    = req_tdata[apal_pkg::LINE_COUNT-1:0];
      item_in.web_command    =
         req_tdata[apal_pkg::LINE_COUNT +: apal_pkg::WEB_W];
      item_in.override_index =
         req_tdata[apal_pkg::LINE_COUNT + apal_pkg::WEB_W +: apal_pkg::OUT_IDX_W];
      item_in.override_mode  =
         req_tdata[apal_pkg::LINE_COUNT + apal_pkg::WEB_W + apal_pkg::OUT_IDX_W
                   +: apal_pkg::MODE_W];
      valid_in = take || (valid_ff && !core_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/apal_core.sv =====
module apal_core (
   input  logic                             clock,
   input  logic                             reset,
   input  apal_pkg::cfg_type                cfg,
   input  logic                             item_valid,
   input  apal_pkg::item_type               item,
   output logic                             core_ready,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [apal_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic                                       armed_ff, armed_in;
   logic                                       latch_ff, latch_in;
   logic [apal_pkg::OUTPUT_COUNT-1:0][apal_pkg::MODE_W-1:0] modes_ff, modes_in;
   logic                                       rsp_valid_ff, rsp_valid_in;
   logic [apal_pkg::RSP_DATA_W-1:0]            rsp_data_ff, rsp_data_in;
   logic [apal_pkg::OUTPUT_COUNT-1:0]          drive;
   logic [apal_pkg::LINE_COUNT-1:0]            diff;
   logic                                       arm_off, disarm_off;
   logic                                       load;
   logic [apal_pkg::STATE_IDX_W-1:0]           st;
   logic [apal_pkg::CODE_W-1:0]                code;
   logic [3:0]                                 set;

   assign core_ready = !rsp_valid_ff || rsp_tready;
   assign load       = item_valid && core_ready;

   always_comb begin
      diff       = item.line_levels ^ cfg.line_normal;
      arm_off    = 1'b0;
      disarm_off = 1'b0;
      // An index beyond the last line never counts as off normal.
      for (int i = 0; i < apal_pkg::LINE_COUNT; i++) begin
         if ({2'b00, cfg.arm_idx} == 6'(i)) begin
            arm_off = diff[i];
         end
         if ({2'b00, cfg.disarm_idx} == 6'(i)) begin
            disarm_off = diff[i];
         end
      end

      armed_in = armed_ff;
      latch_in = latch_ff;
      modes_in = modes_ff;
      if (item.kind == apal_pkg::KIND_TICK) begin
         if (arm_off || item.web_command == apal_pkg::WEB_ARM) begin
            armed_in = 1'b1;
         end else if (disarm_off || item.web_command == apal_pkg::WEB_DISARM) begin
            armed_in = 1'b0;
            latch_in = 1'b0;
         end
         if (armed_in && !latch_in && (|diff)) begin
            latch_in = 1'b1;
         end
      end else begin
         // Out-of-range output index drops the update.
         for (int i = 0; i < apal_pkg::OUTPUT_COUNT; i++) begin
            if ({2'b00, item.override_index} == 5'(i)) begin
               modes_in[i] = item.override_mode;
            end
         end
      end

      st = {latch_in, armed_in};
      for (int i = 0; i < apal_pkg::OUTPUT_COUNT; i++) begin
         code = cfg.cond_codes[i*apal_pkg::CODE_W +: apal_pkg::CODE_W];
         set  = apal_pkg::cond_set(code);
         case (apal_pkg::mode_type'(modes_in[i]))
            apal_pkg::MODE_AUTO: drive[i] = set[st];
            apal_pkg::MODE_ON:   drive[i] = 1'b1;
            default:             drive[i] = 1'b0;
         endcase
      end

      rsp_data_in = '0;
      rsp_data_in[apal_pkg::RSP_FIELDS_W-1:0] = {drive, latch_in, armed_in};
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         latch_ff     <= 1'b0;
         modes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            armed_ff <= armed_in;
            latch_ff <= latch_in;
            modes_ff <= modes_in;
         end
      end
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/apal_checker.sv =====
`include "assert_macros.svh"

module apal_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [apal_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // Hold a stalled result.
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   // Reset empties the result register.
   `CHK_ASSERT_ALWAYS(a_rsp_reset, clock, $past(reset) |-> !rsp_tvalid)
   // Input stalls only when both stages are full.
   `CHK_ASSERT(a_stall_full, clock, reset, !req_tready |-> rsp_tvalid)
   // The latch is only ever set while armed, and disarming clears it.
   `CHK_ASSERT(a_latch_armed, clock, reset, rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])

endmodule

bind alarm_panel_arm_latch_outputs_top apal_checker u_apal_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/alarm_panel_arm_latch_outputs_top_test.sv =====
module alarm_panel_arm_latch_outputs_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import apal_pkg::*;

   typedef struct packed {
      logic                    armed;
      logic                    violated;
      logic [OUTPUT_COUNT-1:0] drive;
   } panel_status_t;

   // Panel states covered by each condition code, code 0 in the lowest nibble;
   // bit index within a nibble is {violated, armed}.
   localparam logic [63:0] COND_STATE_SETS = 64'h0000_0FED_C768_4210;
   localparam int HOLD_CYCLES = 250;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predicted panel state and its copy of the registers
   cfg_type  cfg = '{line_normal: '0, cond_codes: CODES_RESET,
                     arm_idx: ARM_IDX_RESET, disarm_idx: DISARM_IDX_RESET};
   logic     armed = 1'b0;
   logic     violated = 1'b0;
   mode_type out_modes [OUTPUT_COUNT] = '{default: MODE_AUTO};

   item_type      panel_cmd_q[$];
   panel_status_t panel_status_q[$];
   item_type      drv_item;
   panel_status_t want;
   int            errors = 0;
   int            tx_gap_left = 0;
   int            rx_gap_left = 0;
   int            rx_hold_left = 0;
   int            hold_token = 0;
   int            hold_seen = 0;
   bit            steady = 1'b0;

   alarm_panel_arm_latch_outputs_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Advance the predicted panel by one item and return its status.
   function automatic panel_status_t panel_step(input item_type it);
      logic [LINE_COUNT-1:0] off_normal;
      logic                  arm_hit;
      logic                  disarm_hit;
      logic [1:0]            st;
      logic [3:0]            code;
      logic [3:0]            states;
      panel_status_t         res;
      off_normal = it.line_levels ^ cfg.line_normal;
      if (it.kind == KIND_TICK) begin
         arm_hit    = (cfg.arm_idx < LINE_COUNT) ? off_normal[cfg.arm_idx] : 1'b0;
         disarm_hit = (cfg.disarm_idx < LINE_COUNT) ? off_normal[cfg.disarm_idx] : 1'b0;
         if (arm_hit || it.web_command == WEB_ARM) begin
            armed = 1'b1;
         end else if (disarm_hit || it.web_command == WEB_DISARM) begin
            armed    = 1'b0;
            violated = 1'b0;
         end
         if (armed && !violated && off_normal != '0)
            violated = 1'b1;
      end else if (it.override_index < OUTPUT_COUNT) begin
         out_modes[it.override_index] = mode_type'(it.override_mode);
      end
      st           = {violated, armed};
      res.armed    = armed;
      res.violated = violated;
      for (int i = 0; i < OUTPUT_COUNT; i++) begin
         code   = cfg.cond_codes[CODE_W*i +: CODE_W];
         states = COND_STATE_SETS[4*code +: 4];
         case (out_modes[i])
            MODE_AUTO: res.drive[i] = states[st];
            MODE_ON:   res.drive[i] = 1'b1;
            default:   res.drive[i] = 1'b0;
         endcase
      end
      return res;
   endfunction

   // Mostly no gap, some short ones, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic item_type tick(input logic [LINE_COUNT-1:0] levels, input web_type web);
      item_type it;
      it             = '0;
      it.kind        = KIND_TICK;
      it.line_levels = levels;
      it.web_command = web;
      return it;
   endfunction

   function automatic item_type override_item(input int idx, input mode_type mode);
      item_type it;
      it                = '0;
      it.kind           = KIND_OVERRIDE;
      it.override_index = OUT_IDX_W'(idx);
      it.override_mode  = mode;
      return it;
   endfunction

   // Ticks mostly at normal levels or with one line tripped; the rest is noise.
   function automatic item_type random_item();
      item_type it;
      int       r;
      it.kind           = ($urandom_range(0, 4) == 0) ? KIND_OVERRIDE : KIND_TICK;
      it.override_index = OUT_IDX_W'($urandom_range(0, 7));
      it.override_mode  = MODE_W'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 40)
         it.line_levels = cfg.line_normal;
      else if (r < 65)
         it.line_levels = cfg.line_normal ^ (LINE_COUNT'(1) << $urandom_range(0, LINE_COUNT-1));
      else
         it.line_levels = LINE_COUNT'($urandom);
      r = $urandom_range(0, 99);
      if (r < 60)
         it.web_command = WEB_NONE;
      else if (r < 75)
         it.web_command = WEB_ARM;
      else if (r < 90)
         it.web_command = WEB_DISARM;
      else
         it.web_command = WEB_UNUSED;
      return it;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            panel_status_q.push_back(panel_step(drv_item));
         if (!req_tvalid || req_tready) begin
            if (tx_gap_left > 0) begin
               tx_gap_left--;
               req_tvalid <= 1'b0;
            end else if (panel_cmd_q.size() > 0) begin
               drv_item = panel_cmd_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_DATA_W'({drv_item.override_mode, drv_item.override_index,
                                          drv_item.web_command, drv_item.line_levels});
               req_tuser  <= drv_item.kind;
               tx_gap_left = steady ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (panel_status_q.size() == 0) begin
               $display("%0t: unexpected result, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = panel_status_q.pop_front();
               if (rsp_tdata[0] !== want.armed) begin
                  $display("%0t: is_armed expected %0b actual %0b",
                           $time, want.armed, rsp_tdata[0]);
                  errors++;
               end
               if (rsp_tdata[1] !== want.violated) begin
                  $display("%0t: is_violated expected %0b actual %0b",
                           $time, want.violated, rsp_tdata[1]);
                  errors++;
               end
               if (rsp_tdata[2 +: OUTPUT_COUNT] !== want.drive) begin
                  $display("%0t: output_drive expected %b actual %b",
                           $time, want.drive, rsp_tdata[2 +: OUTPUT_COUNT]);
                  errors++;
               end
            end
         end
         if (hold_token != hold_seen) begin
            hold_seen    = hold_token;
            rx_hold_left = HOLD_CYCLES;
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rx_gap_left = steady ? 0 : pick_gap();
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_LINE_NORMAL: cfg.line_normal = val[LINE_COUNT-1:0];
         CSR_COND_CODES:  cfg.cond_codes  = val[CODES_W-1:0];
         CSR_ARM_IDX:     cfg.arm_idx     = val[LINE_IDX_W-1:0];
         CSR_DISARM_IDX:  cfg.disarm_idx  = val[LINE_IDX_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_panel_cfg(input logic [LINE_COUNT-1:0] normal,
                                input logic [CODES_W-1:0] codes,
                                input logic [LINE_IDX_W-1:0] arm_idx,
                                input logic [LINE_IDX_W-1:0] disarm_idx);
      write_reg(CSR_LINE_NORMAL, CSR_DATA_W'(normal));
      write_reg(CSR_COND_CODES, CSR_DATA_W'(codes));
      write_reg(CSR_ARM_IDX, CSR_DATA_W'(arm_idx));
      write_reg(CSR_DISARM_IDX, CSR_DATA_W'(disarm_idx));
      @(negedge clock);
   endtask

   // Hold until every queued transfer has gone through and every result came back.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (panel_cmd_q.size() != 0 || req_tvalid || panel_status_q.size() != 0);
   endtask

   task automatic queue_random(input int count);
      repeat (count) panel_cmd_q.push_back(random_item());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: arm, disarm, latch and override corners at reset settings
      panel_cmd_q.push_back(tick('0, WEB_NONE));
      panel_cmd_q.push_back(override_item(7, MODE_ON));
      panel_cmd_q.push_back(tick('0, WEB_ARM));
      panel_cmd_q.push_back(tick(10'h200, WEB_NONE));
      panel_cmd_q.push_back(tick('0, WEB_NONE));
      panel_cmd_q.push_back(tick('0, WEB_DISARM));
      panel_cmd_q.push_back(tick('0, WEB_DISARM));
      panel_cmd_q.push_back(tick(10'h001, WEB_NONE));
      panel_cmd_q.push_back(tick(10'h002, WEB_NONE));
      panel_cmd_q.push_back(tick(10'h003, WEB_DISARM));
      panel_cmd_q.push_back(tick(10'h3FF, WEB_UNUSED));
      panel_cmd_q.push_back(tick(10'h002, WEB_ARM));
      panel_cmd_q.push_back(tick('0, WEB_UNUSED));
      for (int i = 0; i < OUTPUT_COUNT; i++)
         panel_cmd_q.push_back(override_item(i, MODE_ON));
      panel_cmd_q.push_back(override_item(0, MODE_OFF));
      panel_cmd_q.push_back(override_item(3, MODE_UNUSED));
      panel_cmd_q.push_back(override_item(6, MODE_OFF));
      panel_cmd_q.push_back(tick('0, WEB_DISARM));
      panel_cmd_q.push_back(override_item(0, MODE_AUTO));
      panel_cmd_q.push_back(override_item(3, MODE_AUTO));
      wait_drained();

      set_panel_cfg(10'h3FF, 28'hFFF_FFFF, 4'd9, 4'd0);
      queue_random(103);
      wait_drained();

      // stall the result side while items keep coming
      set_panel_cfg(LINE_COUNT'($urandom), 28'h765_4321, 4'd10, 4'd15);
      queue_random(103);
      hold_token = hold_token + 1;
      wait_drained();

      set_panel_cfg('0, 28'hEDC_BA98, 4'd3, 4'd3);
      queue_random(103);
      wait_drained();

      steady = 1'b1;
      set_panel_cfg(10'h2AA, '0, 4'd15, 4'd9);
      queue_random(103);
      wait_drained();
      steady = 1'b0;

      set_panel_cfg(10'h155, 28'hA98_7654, 4'd5, 4'd2);
      queue_random(52);
      wait_drained();
      queue_random(51);
      wait_drained();

      set_panel_cfg(LINE_COUNT'($urandom), CODES_W'($urandom),
                    LINE_IDX_W'($urandom_range(0, 15)), LINE_IDX_W'($urandom_range(0, 15)));
      queue_random(103);
      wait_drained();

      set_panel_cfg('0, CODES_RESET, ARM_IDX_RESET, DISARM_IDX_RESET);
      queue_random(103);
      wait_drained();

      set_panel_cfg(LINE_COUNT'($urandom), CODES_W'($urandom),
                    LINE_IDX_W'($urandom_range(0, 9)), LINE_IDX_W'($urandom_range(0, 9)));
      queue_random(103);
      wait_drained();

      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/apal_pkg.sv
rtl/apal_csr.sv
rtl/apal_in_reg.sv
rtl/apal_core.sv
rtl/alarm_panel_arm_latch_outputs_top.sv
rtl/apal_checker.sv
bench/alarm_panel_arm_latch_outputs_top_test.sv
